[rtl/core/saabb_pkg.sv]
// Shared types and constants for the swept AABB collision test.
// Used by the axis preparation logic and by the top level; no dependencies.
package saabb_pkg;

	// Internal time values are signed 64-bit words.
	localparam int TIME_W = 64;

	// Largest time magnitude a quotient may take.
	localparam logic [62:0] TIME_SAT = '1;

	// Bound used for an axis that never leaves overlap.
	localparam logic signed [TIME_W-1:0] TIME_UNB = 64'sh4000_0000_0000_0000;

	// Contact normal codes.
	localparam logic [1:0] SIDE_MINUS_X = 2'd0;
	localparam logic [1:0] SIDE_PLUS_X  = 2'd1;
	localparam logic [1:0] SIDE_MINUS_Y = 2'd2;
	localparam logic [1:0] SIDE_PLUS_Y  = 2'd3;

	// Per-axis flags that travel beside the dividers.
	typedef struct packed {
		logic neg_enter;
		logic neg_leave;
		logic vel_zero;
		logic overlap;
		logic vel_neg;
	} axis_flags_t;

endpackage

[rtl/core/saabb_axis_prep.sv]
// Per-axis preparation: chooses entry and exit gaps by velocity sign and
// splits them into magnitudes and quotient signs. Depends on saabb_pkg.
module saabb_axis_prep
	import saabb_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic signed [COORD_WIDTH+1:0] gap_lo,
	input  logic signed [COORD_WIDTH+1:0] gap_hi,
	input  logic signed [COORD_WIDTH-1:0] vel,
	output logic        [COORD_WIDTH:0]   enter_mag,
	output logic        [COORD_WIDTH:0]   leave_mag,
	output logic        [COORD_WIDTH-1:0] vel_mag,
	output axis_flags_t                   flags
);

	localparam int GW = COORD_WIDTH + 2;

	logic                 vel_pos;
	logic signed [GW-1:0] enter_num;
	logic signed [GW-1:0] leave_num;
	logic        [GW-1:0] enter_abs;
	logic        [GW-1:0] leave_abs;
	logic        [COORD_WIDTH-1:0] vel_abs;

	// The approaching border gap is the entry gap.
	assign vel_pos   = !vel[COORD_WIDTH-1] && (vel != '0);
	assign enter_num = vel_pos ? gap_lo : gap_hi;
	assign leave_num = vel_pos ? gap_hi : gap_lo;

	// Magnitudes of the gaps and of the velocity.
	assign enter_abs = enter_num[GW-1] ? GW'(-enter_num) : GW'(enter_num);
	assign leave_abs = leave_num[GW-1] ? GW'(-leave_num) : GW'(leave_num);
	assign vel_abs   = vel[COORD_WIDTH-1] ? COORD_WIDTH'(-vel) : COORD_WIDTH'(vel);

	assign enter_mag = enter_abs[COORD_WIDTH:0];
	assign leave_mag = leave_abs[COORD_WIDTH:0];
	assign vel_mag   = vel_abs;

	// Quotient signs, and the strict overlap test for a still axis.
	always_comb begin
		flags.neg_enter = enter_num[GW-1] != vel[COORD_WIDTH-1];
		flags.neg_leave = leave_num[GW-1] != vel[COORD_WIDTH-1];
		flags.vel_zero  = (vel == '0);
		flags.overlap   = gap_lo[GW-1] && !gap_hi[GW-1] && (gap_hi != '0);
		flags.vel_neg   = vel[COORD_WIDTH-1];
	end

endmodule

[rtl/core/saabb_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, computing
// (num << FRAC_BITS) / den on magnitudes. No package dependencies.
module saabb_div_pipe #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [COORD_WIDTH:0]       num,
	input  logic [COORD_WIDTH-1:0]     den,
	output logic [COORD_WIDTH+FRAC_BITS:0] quo
);

	localparam int NW = COORD_WIDTH + 1;
	localparam int DW = NW + FRAC_BITS;
	localparam int RW = COORD_WIDTH;

	logic [RW-1:0] rem_s [DW];
	logic [DW-1:0] dvd_s [DW];
	logic [RW-1:0] den_s [DW];
	logic [DW-1:0] quo_s [DW];

	// Each stage brings down one dividend bit and subtracts when it can.
	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [DW-1:0] dvd_in;
		logic [RW-1:0] den_in;
		logic [DW-1:0] quo_in;
		logic [RW:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = {num, {FRAC_BITS{1'b0}}};
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = {rem_in, dvd_in[DW-1-k]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
				dvd_s[k] <= dvd_in;
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[DW-2:0], take};
			end
		end
	end

	assign quo = quo_s[DW-1];

endmodule

[rtl/core/swept_aabb_collision_test_top.sv]
// Channel   Signals                              Transfer condition
// input     in_valid, in_ready, ten fields       in_valid && in_ready
// output    out_valid, out_ready, three fields   out_valid && out_ready
// config    cfg_we, cfg_wdata                    cfg_we
//
// One box pair is taken every cycle while the output is not stalled; the
// dividers produce one quotient bit per stage.
// Reset clears the valid bits and loads frame_time with 1.0.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Depends on saabb_pkg, saabb_axis_prep and saabb_div_pipe.
module swept_aabb_collision_test_top
	import saabb_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic        [COORD_WIDTH-2:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] self_center_x,
	input  logic signed [COORD_WIDTH-1:0] self_center_y,
	input  logic        [COORD_WIDTH-2:0] self_half_w,
	input  logic        [COORD_WIDTH-2:0] self_half_h,
	input  logic signed [COORD_WIDTH-1:0] other_center_x,
	input  logic signed [COORD_WIDTH-1:0] other_center_y,
	input  logic        [COORD_WIDTH-2:0] other_half_w,
	input  logic        [COORD_WIDTH-2:0] other_half_h,
	input  logic signed [COORD_WIDTH-1:0] vel_x,
	input  logic signed [COORD_WIDTH-1:0] vel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] impact_time,
	output logic        [1:0]             contact_side
);

	localparam int CW = COORD_WIDTH;
	localparam int GW = CW + 2;
	localparam int NW = CW + 1;
	localparam int DW = NW + FRAC_BITS;
	localparam int QW = (DW > 63) ? DW : 63;

	logic en;
	logic [CW-2:0] frame_q;

	// Register holding the latest allowed entry time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= (CW-1)'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			frame_q <= cfg_wdata;
		end
	end

	// The pipeline moves as one whenever the output slot can be filled.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: border gaps on both axes.
	logic                 valid_s1;
	logic signed [GW-1:0] gxl_s1, gxh_s1, gyl_s1, gyh_s1;
	logic signed [CW-1:0] vx_s1, vy_s1;

	function automatic logic signed [GW-1:0] sx(input logic signed [CW-1:0] c);
		return GW'(c);
	endfunction

	function automatic logic signed [GW-1:0] zx(input logic [CW-2:0] h);
		return $signed({3'b000, h});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gxl_s1 <= sx(self_center_x) - zx(self_half_w) - sx(other_center_x)
				- zx(other_half_w);
			gxh_s1 <= sx(self_center_x) + zx(self_half_w) - sx(other_center_x)
				+ zx(other_half_w);
			gyl_s1 <= sx(self_center_y) - zx(self_half_h) - sx(other_center_y)
				- zx(other_half_h);
			gyh_s1 <= sx(self_center_y) + zx(self_half_h) - sx(other_center_y)
				+ zx(other_half_h);
			vx_s1  <= vel_x;
			vy_s1  <= vel_y;
		end
	end

	// Stage 2: divider operands and signs.
	logic [NW-1:0] exm_c, lxm_c, eym_c, lym_c;
	logic [CW-1:0] vxm_c, vym_c;
	axis_flags_t   fx_c, fy_c;

	saabb_axis_prep #(.COORD_WIDTH(CW)) u_prep_x (
		.gap_lo(gxl_s1), .gap_hi(gxh_s1), .vel(vx_s1),
		.enter_mag(exm_c), .leave_mag(lxm_c), .vel_mag(vxm_c), .flags(fx_c)
	);

	saabb_axis_prep #(.COORD_WIDTH(CW)) u_prep_y (
		.gap_lo(gyl_s1), .gap_hi(gyh_s1), .vel(vy_s1),
		.enter_mag(eym_c), .leave_mag(lym_c), .vel_mag(vym_c), .flags(fy_c)
	);

	logic          valid_s2;
	logic [NW-1:0] exm_s2, lxm_s2, eym_s2, lym_s2;
	logic [CW-1:0] vxm_s2, vym_s2;
	axis_flags_t   fx_s2, fy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exm_s2 <= exm_c;
			lxm_s2 <= lxm_c;
			eym_s2 <= eym_c;
			lym_s2 <= lym_c;
			vxm_s2 <= vxm_c;
			vym_s2 <= vym_c;
			fx_s2  <= fx_c;
			fy_s2  <= fy_c;
		end
	end

	// Four divider lanes for the entry and exit times.
	logic [DW-1:0] qex, qlx, qey, qly;

	saabb_div_pipe #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_ex (
		.clk(clk), .en(en), .num(exm_s2), .den(vxm_s2), .quo(qex)
	);
	saabb_div_pipe #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_lx (
		.clk(clk), .en(en), .num(lxm_s2), .den(vxm_s2), .quo(qlx)
	);
	saabb_div_pipe #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_ey (
		.clk(clk), .en(en), .num(eym_s2), .den(vym_s2), .quo(qey)
	);
	saabb_div_pipe #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_ly (
		.clk(clk), .en(en), .num(lym_s2), .den(vym_s2), .quo(qly)
	);

	// Flags and valid bits delayed alongside the divider stages.
	logic        vld_dly_q [DW];
	axis_flags_t fx_dly_q  [DW];
	axis_flags_t fy_dly_q  [DW];

	for (genvar k = 0; k < DW; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dly_q[k] <= 1'b0;
			end else if (en) begin
				vld_dly_q[k] <= (k == 0) ? valid_s2 : vld_dly_q[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				fx_dly_q[k] <= (k == 0) ? fx_s2 : fx_dly_q[(k == 0) ? 0 : k-1];
				fy_dly_q[k] <= (k == 0) ? fy_s2 : fy_dly_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Clip a quotient magnitude and apply its sign.
	function automatic logic signed [TIME_W-1:0] to_time(input logic [DW-1:0] q,
		input logic neg);
		logic [QW-1:0] qx;
		logic [62:0]   mag;
		qx  = QW'(q);
		mag = (qx > QW'(TIME_SAT)) ? TIME_SAT : qx[62:0];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// Stage 3: signed times and per-axis acceptance.
	logic signed [TIME_W-1:0] tex_c, tlx_c, tey_c, tly_c, frame_t;
	axis_flags_t fx_d, fy_d;

	assign fx_d    = fx_dly_q[DW-1];
	assign fy_d    = fy_dly_q[DW-1];
	assign frame_t = $signed(TIME_W'(frame_q));

	always_comb begin
		tex_c = fx_d.vel_zero ? -TIME_UNB : to_time(qex, fx_d.neg_enter);
		tlx_c = fx_d.vel_zero ?  TIME_UNB : to_time(qlx, fx_d.neg_leave);
		tey_c = fy_d.vel_zero ? -TIME_UNB : to_time(qey, fy_d.neg_enter);
		tly_c = fy_d.vel_zero ?  TIME_UNB : to_time(qly, fy_d.neg_leave);
	end

	logic                     valid_s3, okx_s3, oky_s3, vxn_s3, vyn_s3;
	logic signed [TIME_W-1:0] tex_s3, tlx_s3, tey_s3, tly_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= vld_dly_q[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			okx_s3 <= fx_d.vel_zero ? fx_d.overlap
				: (!tlx_c[TIME_W-1] && !(tex_c > frame_t));
			oky_s3 <= fy_d.vel_zero ? fy_d.overlap
				: (!tly_c[TIME_W-1] && !(tey_c > frame_t));
			vxn_s3 <= fx_d.vel_neg;
			vyn_s3 <= fy_d.vel_neg;
			tex_s3 <= tex_c;
			tlx_s3 <= tlx_c;
			tey_s3 <= tey_c;
			tly_s3 <= tly_c;
		end
	end

	// Stage 4: interval overlap, normal choice and output saturation.
	localparam logic signed [TIME_W-1:0] LIM_HI = $signed(TIME_W'({(CW-1){1'b1}}));
	localparam logic signed [TIME_W-1:0] LIM_LO = -LIM_HI - 64'sd1;

	logic                     x_last;
	logic signed [TIME_W-1:0] tmax, tmin, tsat;
	logic                     hit_c;

	always_comb begin
		x_last = tex_s3 > tey_s3;
		tmax   = x_last ? tex_s3 : tey_s3;
		tmin   = (tlx_s3 < tly_s3) ? tlx_s3 : tly_s3;
		hit_c  = okx_s3 && oky_s3 && (tmax < tmin);
		if (tmax > LIM_HI) begin
			tsat = LIM_HI;
		end else if (tmax < LIM_LO) begin
			tsat = LIM_LO;
		end else begin
			tsat = tmax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit         <= hit_c;
			impact_time <= hit_c ? tsat[CW-1:0] : '0;
			if (!hit_c) begin
				contact_side <= SIDE_MINUS_X;
			end else if (x_last) begin
				contact_side <= vxn_s3 ? SIDE_PLUS_X : SIDE_MINUS_X;
			end else begin
				contact_side <= vyn_s3 ? SIDE_PLUS_Y : SIDE_MINUS_Y;
			end
		end
	end

endmodule

[rtl/core/saabb_checker.sv]
// Port-level checks for the swept AABB collision test, bound to the top level.
// Depends on swept_aabb_collision_test_top and saabb_pkg.
module saabb_checker
	import saabb_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   hit,
	input logic [COORD_WIDTH-1:0] impact_time,
	input logic [1:0]             contact_side
);

	// A result waiting for transfer holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit)
			&& $stable(impact_time) && $stable(contact_side))
		else $error("result changed while stalled");

	// The input side stalls exactly when the output slot is blocked.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output stall");

	// A miss carries zero time and the default normal.
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> impact_time == '0 && contact_side == SIDE_MINUS_X)
		else $error("miss result carries nonzero fields");

endmodule

bind swept_aabb_collision_test_top saabb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .hit(hit), .impact_time(impact_time),
	.contact_side(contact_side)
);

[tb/swept_aabb_collision_checker.sv]
// Checker for the swept AABB collision block: predicts each result from the
// accepted box pair and the current frame time, and compares field by field.
// Depends on saabb_pkg for the contact normal codes.
`timescale 1ns / 100ps
module swept_aabb_collision_checker
	import saabb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [30:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] self_center_x,
	input  logic signed [31:0] self_center_y,
	input  logic        [30:0] self_half_w,
	input  logic        [30:0] self_half_h,
	input  logic signed [31:0] other_center_x,
	input  logic signed [31:0] other_center_y,
	input  logic        [30:0] other_half_w,
	input  logic        [30:0] other_half_h,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               hit,
	input  logic signed [31:0] impact_time,
	input  logic        [1:0]  contact_side,
	output int                 fail_count,
	output int                 pending_count
);

	typedef struct packed {
		logic               hit;
		logic signed [31:0] impact;
		logic [1:0]         side;
	} contact_t;

	localparam logic signed [63:0] T_CLIP = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] T_OPEN = 64'sh4000_0000_0000_0000;

	contact_t   contact_q[$];
	logic [30:0] frame_len;

	// Fixed-point time: (gap << 16) / vel, truncated toward zero, clipped.
	function automatic logic signed [63:0] gap_time(input logic signed [63:0] gap,
		input logic signed [63:0] vel);
		logic [127:0] num_mag;
		logic [127:0] den_mag;
		logic [127:0] quot;
		logic signed [63:0] mag;
		num_mag = (gap < 0) ? 128'(-gap) : 128'(gap);
		den_mag = (vel < 0) ? 128'(-vel) : 128'(vel);
		quot = (num_mag << 16) / den_mag;
		mag = (quot > 128'(T_CLIP)) ? T_CLIP : quot[63:0];
		return ((gap < 0) != (vel < 0)) ? -mag : mag;
	endfunction

	// Entry and exit times on one axis; returns 0 when this axis rules out a hit.
	function automatic logic axis_window(input logic signed [63:0] sc, sh, oc, oh, v,
		output logic signed [63:0] t_in, output logic signed [63:0] t_out);
		logic signed [63:0] s_lo, s_hi, o_lo, o_hi;
		s_lo = sc - sh;
		s_hi = sc + sh;
		o_lo = oc - oh;
		o_hi = oc + oh;
		t_in = 0;
		t_out = 0;
		if (v == 0) begin
			t_in = -T_OPEN;
			t_out = T_OPEN;
			return (s_lo < o_hi) && (s_hi > o_lo);
		end
		if (v > 0) begin
			t_in = gap_time(s_lo - o_hi, v);
			t_out = gap_time(s_hi - o_lo, v);
		end else begin
			t_in = gap_time(s_hi - o_lo, v);
			t_out = gap_time(s_lo - o_hi, v);
		end
		return !(t_out < 0 || t_in > $signed({33'd0, frame_len}));
	endfunction

	function automatic contact_t sweep_contact();
		contact_t r;
		logic signed [63:0] ex, lx, ey, ly, t_first, t_last;
		logic ok_x, ok_y;
		r = '0;
		ok_x = axis_window(64'(self_center_x), 64'(self_half_w), 64'(other_center_x),
			64'(other_half_w), 64'(vel_x), ex, lx);
		ok_y = axis_window(64'(self_center_y), 64'(self_half_h), 64'(other_center_y),
			64'(other_half_h), 64'(vel_y), ey, ly);
		if (!ok_x || !ok_y)
			return r;
		t_first = (ex > ey) ? ex : ey;
		t_last = (lx < ly) ? lx : ly;
		if (t_first >= t_last)
			return r;
		r.hit = 1'b1;
		if (ex > ey)
			r.side = (vel_x >= 0) ? SIDE_MINUS_X : SIDE_PLUS_X;
		else
			r.side = (vel_y >= 0) ? SIDE_MINUS_Y : SIDE_PLUS_Y;
		if (t_first > 64'sd2147483647)
			r.impact = 32'sh7FFF_FFFF;
		else if (t_first < -64'sd2147483648)
			r.impact = 32'sh8000_0000;
		else
			r.impact = t_first[31:0];
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending_count = contact_q.size();

	// Track the register, queue predictions on input transfers, check outputs.
	always @(posedge clk or negedge arst_n) begin
		contact_t want;
		if (!arst_n) begin
			frame_len <= 31'h10000;
			fail_count = 0;
			contact_q.delete();
		end else begin
			if (in_valid && in_ready)
				contact_q.push_back(sweep_contact());
			if (out_valid && out_ready) begin
				if (contact_q.size() == 0) begin
					report("unexpected result", 32'(hit), 0);
				end else begin
					want = contact_q.pop_front();
					if (hit !== want.hit)
						report("hit", 32'(hit), 32'(want.hit));
					if (impact_time !== want.impact)
						report("impact_time", impact_time, want.impact);
					if (contact_side !== want.side)
						report("contact_side", 32'(contact_side), 32'(want.side));
				end
			end
			if (cfg_we)
				frame_len <= cfg_wdata;
		end
	end

endmodule

[tb/tb_swept_aabb_collision_test_top.sv]
// Testbench top for the swept AABB collision block: drives box pairs and
// frame time settings, and gives the verdict from the checker's failure count.
// Depends on the block and swept_aabb_collision_checker.
`timescale 1ns / 100ps
module tb_swept_aabb_collision_test_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] self_center_x = '0, self_center_y = '0;
	logic [30:0] self_half_w = '0, self_half_h = '0;
	logic signed [31:0] other_center_x = '0, other_center_y = '0;
	logic [30:0] other_half_w = '0, other_half_h = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [31:0] impact_time;
	logic [1:0] contact_side;
	int fail_count, pending_count;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit calm_out = 1'b0;

	always #5 clk = ~clk;

	swept_aabb_collision_test_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.self_center_x(self_center_x), .self_center_y(self_center_y),
		.self_half_w(self_half_w), .self_half_h(self_half_h),
		.other_center_x(other_center_x), .other_center_y(other_center_y),
		.other_half_w(other_half_w), .other_half_h(other_half_h),
		.vel_x(vel_x), .vel_y(vel_y),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit),
		.impact_time(impact_time), .contact_side(contact_side)
	);

	swept_aabb_collision_checker u_checker (.*);

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("swept_aabb_collision_test_top: mismatch");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	// Receiver stalls at random, now and then for a long stretch, with calm
	// stretches where it stays ready.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (calm_out || $urandom_range(0, 9) < 6) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 15) == 0) begin
			out_ready <= 1'b0;
			hold_cycles <= $urandom_range(5, 40);
		end else begin
			out_ready <= ($urandom_range(0, 1) == 1);
		end
	end

	task automatic idle_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	// One transfer; valid stays high across back-to-back items.
	task automatic send_pair(input logic signed [31:0] scx, scy, input logic [30:0] shw, shh,
		input logic signed [31:0] ocx, ocy, input logic [30:0] ohw, ohh,
		input logic signed [31:0] vx, vy, input bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			idle_cycles(n);
		end
		in_valid <= 1'b1;
		self_center_x <= scx; self_center_y <= scy;
		self_half_w <= shw; self_half_h <= shh;
		other_center_x <= ocx; other_center_y <= ocy;
		other_half_w <= ohw; other_half_h <= ohh;
		vel_x <= vx; vel_y <= vy;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		idle_cycles(DRAIN_CYCLES);
	endtask

	task automatic set_frame(input logic [30:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord(input int mode);
		case (mode)
			0: return $signed($urandom);
			1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic logic [30:0] rand_half(input int mode);
		case (mode)
			0: return 31'($urandom);
			1: return 31'($urandom_range(0, 32'h0003_0000));
			default: return 31'($urandom_range(0, 32'h0080_0000));
		endcase
	endfunction

	// Random pairs: mostly near, mostly small, with occasional full range and zero axes.
	task automatic send_random(input int count, input bit gaps);
		int mode;
		logic signed [31:0] scx, scy, vx, vy;
		for (int i = 0; i < count; i++) begin
			mode = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 2 : 1);
			scx = rand_coord(mode);
			scy = rand_coord(mode);
			vx = ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_coord(mode);
			vy = ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_coord(mode);
			send_pair(scx, scy, rand_half(mode), rand_half(mode),
				scx + rand_coord(mode) / 2, scy + rand_coord(mode) / 2,
				rand_half(mode), rand_half(mode), vx, vy, gaps);
		end
	endtask

	initial begin
		idle_cycles(4);
		arst_n <= 1'b1;
		idle_cycles(2);

		// Directed cases at the reset frame time.
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh30000, 0, 31'h10000, 31'h10000,
			-32'sh20000, 0, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh30000, 0, 31'h10000, 31'h10000,
			32'sh20000, 0, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 0, 0, 31'h10000, 31'h10000, 0, 0, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh50000, 0, 31'h10000, 31'h10000,
			0, 0, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh30000, 32'sh30000, 31'h10000,
			31'h10000, -32'sh20000, -32'sh20000, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 0, -32'sh30000, 31'h10000, 31'h10000,
			0, 32'sh20000, 1'b0);
		send_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		send_pair(0, 0, 31'h7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 31'h7FFF_FFFF,
			1, -1, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh7FFF_0000, 0, 31'h10000, 31'h10000,
			-1, 0, 1'b0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh20000, 0, 0, 31'h10000, 0, 0, 1'b0);

		// Frame time at its extremes, then middle values.
		set_frame('0);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh30000, 0, 31'h10000, 31'h10000,
			-32'sh20000, 0, 1'b0);
		send_random(150, 1'b1);
		set_frame('1);
		send_pair(0, 0, 31'h10000, 31'h10000, 32'sh7000_0000, 0, 31'h10000, 31'h10000,
			-1, 0, 1'b0);
		send_random(300, 1'b1);

		// Pause the sender until every result has arrived.
		drain();
		set_frame(31'h4_0000);
		calm_out = 1'b1;
		send_random(250, 1'b0);
		calm_out = 1'b0;
		set_frame(31'($urandom));
		send_random(300, 1'b1);
		set_frame(31'h10000);
		send_random(300, 1'b1);

		drain();
		if (fail_count == 0)
			$display("swept_aabb_collision_test_top: match");
		else
			$display("swept_aabb_collision_test_top: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/core/saabb_pkg.sv
rtl/core/saabb_axis_prep.sv
rtl/core/saabb_div_pipe.sv
rtl/core/swept_aabb_collision_test_top.sv
rtl/core/saabb_checker.sv
tb/swept_aabb_collision_checker.sv
tb/tb_swept_aabb_collision_test_top.sv
